// ----- hdl/g711c_pkg.sv -----
// Shared types and constants for the G.711 companding core.
package g711c_pkg;

   localparam logic [1:0] ACT_ALAW_ENC = 2'd0;
   localparam logic [1:0] ACT_ALAW_DEC = 2'd1;
   localparam logic [1:0] ACT_ULAW_DEC = 2'd2;

   localparam logic [7:0]  ALAW_XOR_MASK = 8'hD5;
   localparam logic [7:0]  ULAW_BIAS_8   = 8'h84;
   localparam logic [15:0] ULAW_BIAS     = 16'h0084;
   localparam logic [15:0] PCM_MOST_NEG  = 16'h8000;
   localparam logic [14:0] PCM_MAX_MAG   = 15'h7FFF;

   typedef struct packed {
      logic [1:0]         action;
      logic signed [15:0] pcm_sample;
      logic [7:0]         code_byte;
      logic               last_in;
   } g711c_req_type;

   typedef struct packed {
      logic [7:0]         code_out;
      logic signed [15:0] sample_out;
      logic               last_out;
   } g711c_rsp_type;

endpackage

// ----- hdl/g711_alaw_ulaw_codec_core.sv -----
// Top level of the G.711 companding core: input register, companding logic, result register.
// One transaction is accepted per clock while req_ready is high. Each item is held in the input
// register, then its result is loaded into the result register and shows on rsp_valid;
// throughput is one item per cycle while rsp_ready does not stall, set by the single-pass
// companding logic between the two registers. Each item selects A-law encode, A-law decode
// or mu-law decode; an unused action code returns zero code and sample.
// The input register can still take an item while a finished result waits on rsp_ready, so the
// core holds up to two items before req_ready drops.
module g711_alaw_ulaw_codec_core (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  g711c_pkg::g711c_req_type  req_data,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output g711c_pkg::g711c_rsp_type  rsp_data
);
   import g711c_pkg::*;

   logic          s1_valid_ff, s1_valid_in;
   g711c_req_type s1_item_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   g711c_rsp_type rsp_data_ff;
   g711c_rsp_type s1_result;
   logic          out_free;
   logic          s1_adv;
   logic          req_take;

   g711c_compand u_compand (
      .item   (s1_item_ff),
      .result (s1_result)
   );

   assign out_free     = !rsp_valid_ff || rsp_ready;
   assign s1_adv       = s1_valid_ff && out_free;
   assign req_ready    = !s1_valid_ff || out_free;
   assign req_take     = req_valid && req_ready;
   assign s1_valid_in  = req_take || (s1_valid_ff && !out_free);
   assign rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload: load on transaction, hold otherwise
   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_item_ff <= req_data;
      end
      if (s1_adv) begin
         rsp_data_ff <= s1_result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   a_stall_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("input taken while both stages are stalled");

   a_last_follows: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> (rsp_data_ff.last_out == $past(s1_item_ff.last_in)))
      else $error("last flag not carried to the result");

   a_encode_sample_zero: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && (s1_item_ff.action == ACT_ALAW_ENC)) |=> (rsp_data_ff.sample_out == 16'sd0))
      else $error("encode result carries a nonzero sample");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> (!rsp_valid_ff && !s1_valid_ff))
      else $error("pipeline not empty after reset");

endmodule

// ----- hdl/g711c_compand.sv -----
// Combinational A-law encode, A-law decode and mu-law decode for one item.
module g711c_compand (
   input  g711c_pkg::g711c_req_type item,
   output g711c_pkg::g711c_rsp_type result
);
   import g711c_pkg::*;

   logic [15:0] raw;
   logic        enc_neg;
   logic [14:0] enc_mag;
   logic [2:0]  enc_seg;
   logic [3:0]  enc_shift;
   logic [14:0] enc_shifted;
   logic [7:0]  enc_code;

   logic [7:0]  a_v;
   logic [2:0]  a_seg;
   logic [8:0]  a_base;
   logic [2:0]  a_shift;
   logic [14:0] a_mag;
   logic [15:0] a_sample;

   logic [7:0]  u_v;
   logic [2:0]  u_seg;
   logic [7:0]  u_base;
   logic [14:0] u_t;
   logic [15:0] u_sample;

   // A-law encode: saturate the most negative sample instead of wrapping
   assign raw     = item.pcm_sample;
   assign enc_neg = raw[15];

   always_comb begin
      logic [15:0] neg_raw;
      neg_raw = 16'd0 - raw;
      if (!enc_neg) begin
         enc_mag = raw[14:0];
      end else if (raw == PCM_MOST_NEG) begin
         enc_mag = PCM_MAX_MAG;
      end else begin
         enc_mag = neg_raw[14:0];
      end
   end

   // leading-one search over bits 14..8
   always_comb begin
      if (enc_mag[14]) begin
         enc_seg = 3'd7;
      end else if (enc_mag[13]) begin
         enc_seg = 3'd6;
      end else if (enc_mag[12]) begin
         enc_seg = 3'd5;
      end else if (enc_mag[11]) begin
         enc_seg = 3'd4;
      end else if (enc_mag[10]) begin
         enc_seg = 3'd3;
      end else if (enc_mag[9]) begin
         enc_seg = 3'd2;
      end else if (enc_mag[8]) begin
         enc_seg = 3'd1;
      end else begin
         enc_seg = 3'd0;
      end
   end

   assign enc_shift   = (enc_seg == 3'd0) ? 4'd4 : ({1'b0, enc_seg} + 4'd3);
   assign enc_shifted = enc_mag >> enc_shift;
   assign enc_code    = {enc_neg, enc_seg, enc_shifted[3:0]} ^ ALAW_XOR_MASK;

   // A-law decode
   assign a_v      = item.code_byte ^ ALAW_XOR_MASK;
   assign a_seg    = a_v[6:4];
   assign a_base   = {(a_seg != 3'd0), a_v[3:0], 4'b1000};
   assign a_shift  = (a_seg > 3'd1) ? (a_seg - 3'd1) : 3'd0;
   assign a_mag    = {6'd0, a_base} << a_shift;
   assign a_sample = a_v[7] ? (16'd0 - {1'b0, a_mag}) : {1'b0, a_mag};

   // mu-law decode: biased segment value, bias removed after the shift
   assign u_v      = ~item.code_byte;
   assign u_seg    = u_v[6:4];
   assign u_base   = {1'b0, u_v[3:0], 3'b000} + ULAW_BIAS_8;
   assign u_t      = {7'd0, u_base} << u_seg;
   assign u_sample = u_v[7] ? (ULAW_BIAS - {1'b0, u_t}) : ({1'b0, u_t} - ULAW_BIAS);

   always_comb begin
      result.code_out   = 8'd0;
      result.sample_out = 16'sd0;
      result.last_out   = item.last_in;
      case (item.action)
         ACT_ALAW_ENC: result.code_out   = enc_code;
         ACT_ALAW_DEC: result.sample_out = $signed(a_sample);
         ACT_ULAW_DEC: result.sample_out = $signed(u_sample);
         default:      result.code_out   = 8'd0;
      endcase
   end

endmodule
